### hdl/efd_pkg.sv
// shared types, constants and the crc byte update for the escaped frame deframer
package efd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int LEN_W       = 10;
    localparam int TDATA_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int COUNT_BITS_DEFAULT = 10;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] FRAME_END_RESET = 8'hC0;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'hDB;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 10'd234;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_END = 2'd0,
        REG_ESCAPE    = 2'd1,
        REG_MAX_LEN   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_GOOD      = 2'd0,
        STATUS_CRC_ERR   = 2'd1,
        STATUS_TOO_SHORT = 2'd2,
        STATUS_TOO_LONG  = 2'd3
    } frame_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [LEN_W-1:0]  max_content_len;
    } efd_cfg_t;

    // reflected crc-16, one byte lsb first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_in);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int k = 0; k < BYTE_W; k++) begin
            fb  = crc[0] ^ data_in[k];
            crc = (crc >> 1) ^ (fb ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

### hdl/escaped_frame_deframer_crc16_core.sv
// escaped frame deframer with crc-16 check, top level
//
//  channel | direction | fields (lsb first)
//  s_axis  | in        | tdata: line_byte[7:0]
//  m_axis  | out       | tdata: payload_byte[7:0], frame_status[9:8]; tuser: item_kind;
//          |           | tlast: frame_last
//  cfg     | in        | cfg_index: register index; cfg_data: value
//
// one line byte per cycle while s_axis_tready is high; each item is decoded and the crc
// updated in the cycle it is accepted, and the output register captures its result as it is accepted
// the output register lets s_axis take a new item while a result is being taken
// m_axis stalls hold the output register and drop s_axis_tready only while it is full
// rst_n clears frame state, output valid and the registers to their reset values
module escaped_frame_deframer_crc16_core #(
    parameter int COUNT_BITS = efd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [efd_pkg::BYTE_W-1:0]        s_axis_tdata,   // line_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [efd_pkg::TDATA_W-1:0]       m_axis_tdata,   // payload_byte, frame_status
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser,   // item_kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CMP_W = (COUNT_BITS > efd_pkg::LEN_W) ? COUNT_BITS : efd_pkg::LEN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    efd_pkg::efd_cfg_t cfg;

    efd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // frame state
    logic                          inside_reg,  inside_next;
    logic                          esc_reg,     esc_next;
    logic                          over_reg,    over_next;
    logic [efd_pkg::CRC_W-1:0]     crc_reg,     crc_next;
    logic [efd_pkg::BYTE_W-1:0]    held0_reg,   held0_next;
    logic [efd_pkg::BYTE_W-1:0]    held1_reg,   held1_next;
    logic [COUNT_BITS-1:0]         count_reg,   count_next;

    // output register
    logic                          m_valid_reg;
    logic [efd_pkg::BYTE_W-1:0]    m_byte_reg;
    efd_pkg::frame_status_t        m_status_reg;
    efd_pkg::item_kind_t           m_kind_reg;
    logic                          m_last_reg;

    logic                          emit;
    efd_pkg::item_kind_t           emit_kind;
    logic [efd_pkg::BYTE_W-1:0]    emit_byte;
    efd_pkg::frame_status_t        emit_status;
    efd_pkg::frame_status_t        close_status;

    logic                          s_fire;
    logic                          at_limit;
    logic [efd_pkg::BYTE_W-1:0]    b;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign b             = s_axis_tdata;

    assign at_limit = (CMP_W'(count_reg) >= CMP_W'(cfg.max_content_len)) ||
                      (count_reg == COUNT_MAX);

    always_comb
    begin
        if (over_reg)
            close_status = efd_pkg::STATUS_TOO_LONG;
        else if (count_reg < COUNT_BITS'(2))
            close_status = efd_pkg::STATUS_TOO_SHORT;
        else if (held0_reg == crc_reg[7:0] && held1_reg == crc_reg[15:8])
            close_status = efd_pkg::STATUS_GOOD;
        else
            close_status = efd_pkg::STATUS_CRC_ERR;
    end

    always_comb
    begin
        inside_next = inside_reg;
        esc_next    = esc_reg;
        over_next   = over_reg;
        crc_next    = crc_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        emit_kind   = efd_pkg::KIND_PAYLOAD;
        emit_byte   = '0;
        emit_status = efd_pkg::STATUS_GOOD;

        if (!inside_reg || (!esc_reg && b == cfg.frame_end_code))
        begin
            // outside a frame (a marker opens one, other bytes are dropped), empty frame restart, or closing marker
            if (inside_reg && count_reg != '0)
            begin
                emit        = 1'b1;
                emit_kind   = efd_pkg::KIND_STATUS;
                emit_status = close_status;
                inside_next = 1'b0;
            end
            else if (b == cfg.frame_end_code)
                inside_next = 1'b1;

            if (b == cfg.frame_end_code)
            begin
                esc_next   = 1'b0;
                over_next  = 1'b0;
                crc_next   = efd_pkg::CRC_INIT;
                held0_next = '0;
                held1_next = '0;
                count_next = '0;
            end
        end
        else if (!esc_reg && b == cfg.escape_code)
            esc_next = 1'b1;
        else
        begin
            esc_next = 1'b0;
            if (!over_reg)
            begin
                if (at_limit)
                    over_next = 1'b1;
                else
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                    held0_next = held1_reg;
                    held1_next = b;
                    // third content byte onward pushes the oldest held byte out
                    if (count_reg >= COUNT_BITS'(2))
                    begin
                        crc_next  = efd_pkg::crc_fold(crc_reg, held0_reg);
                        emit      = 1'b1;
                        emit_byte = held0_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            esc_reg    <= 1'b0;
            over_reg   <= 1'b0;
            crc_reg    <= efd_pkg::CRC_INIT;
            held0_reg  <= '0;
            held1_reg  <= '0;
            count_reg  <= '0;
        end
        else if (s_fire)
        begin
            inside_reg <= inside_next;
            esc_reg    <= esc_next;
            over_reg   <= over_next;
            crc_reg    <= crc_next;
            held0_reg  <= held0_next;
            held1_reg  <= held1_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_fire)
            m_valid_reg <= emit;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && emit)
        begin
            m_kind_reg   <= emit_kind;
            m_byte_reg   <= emit_byte;
            m_status_reg <= emit_status;
            m_last_reg   <= (emit_kind == efd_pkg::KIND_STATUS);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(efd_pkg::TDATA_W - efd_pkg::BYTE_W - 2){1'b0}},
                            m_status_reg, m_byte_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_kind_reg;

    // a status item always carries last, a payload item never does
    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast does not match item kind");

    // payload items carry a zero status field
    a_payload_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:8] == 2'd0))
        else $error("payload item with nonzero status");

    // a status item leaves the block outside a frame
    a_close_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && emit && emit_kind == efd_pkg::KIND_STATUS) |=> !inside_reg)
        else $error("frame still open after status item");

    // an empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

### hdl/efd_cfg_regs.sv
// configuration register file for the escaped frame deframer
module efd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output efd_pkg::efd_cfg_t                 cfg
);

    efd_pkg::efd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_end_code  <= efd_pkg::FRAME_END_RESET;
            cfg_reg.escape_code     <= efd_pkg::ESCAPE_RESET;
            cfg_reg.max_content_len <= efd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                efd_pkg::REG_FRAME_END:
                    cfg_reg.frame_end_code  <= cfg_data[efd_pkg::BYTE_W-1:0];
                efd_pkg::REG_ESCAPE:
                    cfg_reg.escape_code     <= cfg_data[efd_pkg::BYTE_W-1:0];
                efd_pkg::REG_MAX_LEN:
                    cfg_reg.max_content_len <= cfg_data[efd_pkg::LEN_W-1:0];
                default:
                    ; // index beyond the register list is dropped
            endcase
        end
    end

endmodule
